@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker. Every macro samples on the rising
// edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BJSC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BJSC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bjsc_pkg.sv @@
package bjsc_pkg;

   localparam int BJSC_MAX_STEPS_DEFAULT = 511;
   localparam int HEIGHT_W = 9;
   localparam int LIMIT_W  = 9;
   localparam int COUNT_W  = 30;

   localparam logic [COUNT_W-1:0] WAY_MOD = COUNT_W'(1000000007);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW,
      ST_ROW_END,
      ST_FIN
   } bjsc_state_type;

   typedef struct packed {
      logic load;
      logic init_step;
      logic row_step;
      logic row_end;
      logic publish;
   } bjsc_cmd_type;

   typedef struct packed {
      logic too_high;
      logic step_last;
      logic limit_zero;
      logic row_last;
      logic out_free;
   } bjsc_stat_type;

   // Sum of two residues, reduced once.
   function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, WAY_MOD}) begin
         s = s - {1'b0, WAY_MOD};
      end
      return s[COUNT_W-1:0];
   endfunction

endpackage

@@ rtl/bjsc_ctrl.sv @@
module bjsc_ctrl
   import bjsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  bjsc_stat_type stat,
   output bjsc_cmd_type  cmd
);

   bjsc_state_type state_ff;
   bjsc_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.too_high ? ST_FIN : ST_INIT;
            end
         end
         ST_INIT: begin
            if (stat.step_last) begin
               state_in = stat.limit_zero ? ST_FIN : ST_ROW;
            end
         end
         ST_ROW: begin
            if (stat.step_last) begin
               state_in = ST_ROW_END;
            end
         end
         ST_ROW_END: begin
            state_in = stat.row_last ? ST_FIN : ST_ROW;
         end
         ST_FIN: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_INIT:    cmd.init_step = 1'b1;
         ST_ROW:     cmd.row_step  = 1'b1;
         ST_ROW_END: cmd.row_end   = 1'b1;
         ST_FIN:     cmd.publish   = stat.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/bjsc_data.sv @@
module bjsc_data
   import bjsc_pkg::*;
#(
   parameter int MAX_STEPS = BJSC_MAX_STEPS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [HEIGHT_W-1:0] req_stair_height,
   input  logic [LIMIT_W-1:0]  req_jump_limit,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COUNT_W-1:0]  rsp_way_count,
   input  bjsc_cmd_type        cmd,
   output bjsc_stat_type       stat
);

   localparam int RowLen     = MAX_STEPS + 1;
   localparam int StoreDepth = 2 * RowLen;
   localparam int AddrW      = $clog2(StoreDepth);

   // Two rows of the jump table, ping-ponged between source and destination.
   logic [COUNT_W-1:0] row_store_mem [StoreDepth];

   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [HEIGHT_W-1:0] step_ff, step_in;
   logic [LIMIT_W-1:0]  jump_ff, jump_in;
   logic                bank_ff, bank_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  last_ff, last_in;
   logic [COUNT_W-1:0]  rd_ff;
   logic [COUNT_W-1:0]  prev_ff, prev_in;
   logic [COUNT_W-1:0]  out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic [AddrW-1:0]    rd_addr, wr_addr;
   logic [COUNT_W-1:0]  wr_data, term_a, term_b, row_sum;
   logic                wr_en, step_last, too_high;

   assign too_high  = int'(req_stair_height) > MAX_STEPS;
   assign step_last = (step_ff == height_ff);

   // rd_ff holds the source entry one below the current height, prev_ff the
   // entry two below; the lowest heights have no such predecessors.
   assign term_a  = (step_ff != '0) ? rd_ff : '0;
   assign term_b  = (step_ff > HEIGHT_W'(1)) ? prev_ff : '0;
   assign row_sum = add_mod(term_a, term_b);

   assign rd_addr = AddrW'(step_ff) + (bank_ff ? AddrW'(RowLen) : '0);

   always_comb begin
      if (cmd.init_step) begin
         wr_addr = AddrW'(step_ff);
         wr_data = (step_ff == '0) ? COUNT_W'(1) : '0;
      end else begin
         wr_addr = AddrW'(step_ff) + (bank_ff ? '0 : AddrW'(RowLen));
         wr_data = row_sum;
      end
   end
   assign wr_en = cmd.init_step | cmd.row_step;

   always_comb begin
      height_in    = height_ff;
      limit_in     = limit_ff;
      step_in      = step_ff;
      jump_in      = jump_ff;
      bank_in      = bank_ff;
      total_in     = total_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.load) begin
         height_in = req_stair_height;
         limit_in  = (req_jump_limit > req_stair_height) ? req_stair_height : req_jump_limit;
         step_in   = '0;
         jump_in   = '0;
         bank_in   = 1'b0;
         total_in  = (!too_high && req_stair_height == '0) ? COUNT_W'(1) : '0;
      end

      if (cmd.init_step) begin
         step_in = step_last ? '0 : step_ff + HEIGHT_W'(1);
      end

      if (cmd.row_step) begin
         prev_in = rd_ff;
         step_in = step_last ? '0 : step_ff + HEIGHT_W'(1);
         if (step_last) begin
            last_in = row_sum;
         end
      end

      if (cmd.row_end) begin
         total_in = add_mod(total_ff, last_ff);
         bank_in  = ~bank_ff;
         jump_in  = jump_ff + LIMIT_W'(1);
      end

      if (cmd.publish) begin
         out_in       = total_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_store_mem[wr_addr] <= wr_data;
      end
      if (cmd.row_step) begin
         rd_ff <= row_store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      height_ff <= height_in;
      limit_ff  <= limit_in;
      bank_ff   <= bank_in;
      last_ff   <= last_in;
      prev_ff   <= prev_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         jump_ff      <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         jump_ff      <= jump_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign stat.too_high   = too_high;
   assign stat.step_last  = step_last;
   assign stat.limit_zero = (limit_ff == '0);
   assign stat.row_last   = (jump_ff + LIMIT_W'(1) == limit_ff);
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_way_count = out_ff;

endmodule

@@ rtl/bounded_jump_stair_counter.sv @@
// The jump limit K is clipped to the stair height H. A new request is accepted
// only once the previous result has been handed to the result register.
// The row sweep does one modular add and one row store write per cycle.
// Reset is synchronous and active high; it empties the result register and
// returns the controller to idle. The row store is not cleared.
module bounded_jump_stair_counter
   import bjsc_pkg::*;
#(
   parameter int MAX_STEPS = BJSC_MAX_STEPS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [HEIGHT_W-1:0] req_stair_height,
   input  logic [LIMIT_W-1:0]  req_jump_limit,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COUNT_W-1:0]  rsp_way_count
);

   // The controller walks the phases of one transaction: it seeds row zero
   // of the table, sweeps one row per allowed jump, folds the entry at the
   // target height into the running total after each row, and finally
   // hands the total to the result register. The result register sits in
   // the datapath, so a finished result can wait for the consumer while the
   // controller is already back in idle taking the next request.
   bjsc_cmd_type  cmd;
   bjsc_stat_type stat;

   bjsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the two-row table in a simple dual-port memory with
   // a registered read. Each sweep cycle reads the source row at the current
   // height and forms the destination entry from the two entries just below
   // it, which are kept in a small sliding window of registers.
   bjsc_data #(
      .MAX_STEPS (MAX_STEPS)
   ) u_data (
      .clock            (clock),
      .reset            (reset),
      .req_stair_height (req_stair_height),
      .req_jump_limit   (req_jump_limit),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_way_count    (rsp_way_count),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

@@ rtl/bjsc_checker.sv @@
`include "assert_macros.svh"

module bjsc_checker
   import bjsc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [HEIGHT_W-1:0] req_stair_height,
   input logic [LIMIT_W-1:0]  req_jump_limit,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [COUNT_W-1:0]  rsp_way_count
);

   // A result that is not taken stays on the port unchanged.
   `BJSC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_way_count), "result changed while stalled")

   // Every count is a reduced residue.
   `BJSC_ASSERT_IMP(a_rsp_range, rsp_valid, rsp_way_count < WAY_MOD, "count not reduced")

   // Ready is withdrawn after every accepted request.
   `BJSC_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready right after a request")

   // No result appears straight out of reset.
   `BJSC_ASSERT_IMP(a_reset_empty, $past(reset), !rsp_valid, "result valid after reset")

endmodule

bind bounded_jump_stair_counter bjsc_checker u_checker (.*);
